// ===== design/great_circle_distance_defines.svh =====
// Assertion macros used by the great circle distance top level.
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== design/gcd_pkg.sv =====
// Shared constants, types and helper functions of the great circle distance block.
package gcd_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS_DEF = 24;

	localparam int LAT_W = 24;
	localparam int LON_W = 25;
	localparam int RADIUS_W = 24;
	localparam int DIST_W = 34;
	localparam int DIST_SHIFT = 22;

	localparam int TRIG_W = 32;
	localparam int PROD_W = 33;
	localparam int NUM_W = 33;
	localparam int ANG_W = 32;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371;
	localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
	localparam logic [ANG_W-1:0] PI_Q30 = 32'd3373259426;
	localparam logic [ANG_W-1:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 32'sh26DD3B6A;

	typedef struct packed {
		logic signed [TRIG_W-1:0] s;
		logic signed [TRIG_W-1:0] c;
	} sincos_t;

	// Truncated Q30 arctangent of 2^-i.
	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] v;
		unique case (i)
			0: v = 32'h3243F6A8;
			1: v = 32'h1DAC6705;
			2: v = 32'h0FADBAFC;
			3: v = 32'h07F56EA6;
			4: v = 32'h03FEAB76;
			5: v = 32'h01FFD55B;
			6: v = 32'h00FFFAAA;
			7: v = 32'h007FFF55;
			8: v = 32'h003FFFEA;
			9: v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			24: v = 32'h0000003F;
			25: v = 32'h0000001F;
			26: v = 32'h0000000F;
			27: v = 32'h00000008;
			28: v = 32'h00000004;
			29: v = 32'h00000002;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// Q30 product, floor rounded.
	function automatic logic signed [PROD_W-1:0] mulq(input logic signed [PROD_W-1:0] a,
		input logic signed [PROD_W-1:0] b);
		logic signed [2*PROD_W-1:0] p;
		p = a * b;
		return p[PROD_W+29:30];
	endfunction

endpackage

// ===== design/gcd_sincos.sv =====
// Angle reduction and rotation CORDIC giving Q30 sine and cosine of a degree angle.
module gcd_sincos #(
	parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF,
	parameter int IN_W = gcd_pkg::LAT_W
) (
	input logic clk,
	input logic en,
	input logic signed [IN_W-1:0] angle,
	output gcd_pkg::sincos_t trig
);
	import gcd_pkg::*;

	localparam longint FULL = longint'(360) << ANGLE_FRAC_BITS;
	localparam longint HALF = longint'(180) << ANGLE_FRAC_BITS;
	localparam longint QUARTER = longint'(90) << ANGLE_FRAC_BITS;
	localparam int UX_W = ((IN_W > ANGLE_FRAC_BITS + 9) ? IN_W : ANGLE_FRAC_BITS + 9) + 1;
	localparam longint OFFSET = FULL * (((longint'(1) << (IN_W - 1)) + FULL - 1) / FULL);
	localparam int RQ_W = UX_W - ANGLE_FRAC_BITS - 7;
	localparam longint RECIP = ((longint'(1) << UX_W) + FULL - 1) / FULL;
	localparam int R_W = ANGLE_FRAC_BITS + 9;
	localparam int A_W = ANGLE_FRAC_BITS + 7;
	localparam int Z_W = 33;

	localparam logic [UX_W-1:0] OFFSET_V = OFFSET[UX_W-1:0];
	localparam logic [RQ_W-1:0] RECIP_V = RECIP[RQ_W-1:0];
	localparam logic [UX_W+1:0] FULL_W = FULL[UX_W+1:0];
	localparam logic [R_W-1:0] FULL_R = FULL[R_W-1:0];
	localparam logic [R_W-1:0] HALF_R = HALF[R_W-1:0];
	localparam logic [R_W-1:0] QUARTER_R = QUARTER[R_W-1:0];

	logic [UX_W-1:0] ux_s1, ux_s2;
	logic [RQ_W-1:0] q_s2;
	logic [R_W-1:0] r_s3;
	logic [A_W-1:0] a_s4;
	logic sneg_s4, cneg_s4, sneg_s5, cneg_s5;
	logic [31:0] z_s5;
	logic signed [TRIG_W-1:0] cx_s [CORDIC_STEPS];
	logic signed [TRIG_W-1:0] cy_s [CORDIC_STEPS];
	logic signed [Z_W-1:0] cz_s [CORDIC_STEPS];
	logic sn_s [CORDIC_STEPS];
	logic cn_s [CORDIC_STEPS];
	sincos_t trig_s6;

	logic [UX_W+RQ_W-1:0] qp;
	logic [UX_W+1:0] qf, rt, rc;
	logic [R_W-1:0] mag, fold;
	logic sn, cn;
	logic [A_W+24:0] zp;

	assign qp = (UX_W + RQ_W)'(ux_s1) * (UX_W + RQ_W)'(RECIP_V);
	// The reciprocal estimate may overshoot by one period; add it back.
	assign qf = (UX_W + 2)'(q_s2) * FULL_W;
	assign rt = {2'b00, ux_s2} - qf;
	assign rc = rt[UX_W+1] ? rt + FULL_W : rt;

	// Fold to [0, 90] degrees and remember the signs of sine and cosine.
	always_comb begin
		if (r_s3 >= HALF_R) begin
			sn = 1'b1;
			mag = FULL_R - r_s3;
		end else begin
			sn = 1'b0;
			mag = r_s3;
		end
		if (mag > QUARTER_R) begin
			cn = 1'b1;
			fold = HALF_R - mag;
		end else begin
			cn = 1'b0;
			fold = mag;
		end
	end

	assign zp = (A_W + 25)'(a_s4) * (A_W + 25)'(DEG_TO_RAD_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= UX_W'(angle) + OFFSET_V;
			q_s2 <= qp[UX_W+RQ_W-1:UX_W];
			ux_s2 <= ux_s1;
			r_s3 <= rc[R_W-1:0];
			a_s4 <= fold[A_W-1:0];
			sneg_s4 <= sn;
			cneg_s4 <= cn;
			z_s5 <= zp[ANGLE_FRAC_BITS+31:ANGLE_FRAC_BITS];
			sneg_s5 <= sneg_s4;
			cneg_s5 <= cneg_s4;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [TRIG_W-1:0] xi, yi, xn, yn;
		logic signed [Z_W-1:0] zi, zn, at;
		logic si, ci;

		if (i == 0) begin : g_first
			assign xi = CORDIC_GAIN_Q30;
			assign yi = '0;
			assign zi = signed'({1'b0, z_s5});
			assign si = sneg_s5;
			assign ci = cneg_s5;
		end else begin : g_next
			assign xi = cx_s[i-1];
			assign yi = cy_s[i-1];
			assign zi = cz_s[i-1];
			assign si = sn_s[i-1];
			assign ci = cn_s[i-1];
		end

		assign at = signed'({1'b0, atan_q30(i)});

		always_comb begin
			if (!zi[Z_W-1]) begin
				xn = xi - (yi >>> i);
				yn = yi + (xi >>> i);
				zn = zi - at;
			end else begin
				xn = xi + (yi >>> i);
				yn = yi - (xi >>> i);
				zn = zi + at;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cx_s[i] <= xn;
				cy_s[i] <= yn;
				cz_s[i] <= zn;
				sn_s[i] <= si;
				cn_s[i] <= ci;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig_s6.s <= sn_s[CORDIC_STEPS-1] ? -cy_s[CORDIC_STEPS-1] : cy_s[CORDIC_STEPS-1];
			trig_s6.c <= cn_s[CORDIC_STEPS-1] ? -cx_s[CORDIC_STEPS-1] : cx_s[CORDIC_STEPS-1];
		end
	end

	assign trig = trig_s6;

endmodule

// ===== design/gcd_atan2.sv =====
// Vectoring CORDIC giving atan2(num, den) in Q30, clamped to [0, pi].
module gcd_atan2 #(
	parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic en,
	input logic [gcd_pkg::NUM_W-1:0] num,
	input logic signed [gcd_pkg::PROD_W-1:0] den,
	output logic [gcd_pkg::ANG_W-1:0] angle
);
	import gcd_pkg::*;

	localparam int AX_W = 36;
	localparam int AZ_W = 34;

	logic signed [AX_W-1:0] x_s1, y_s1;
	logic signed [AZ_W-1:0] z_s1;
	logic zero_s1;
	logic signed [AX_W-1:0] vx_s [CORDIC_STEPS];
	logic signed [AX_W-1:0] vy_s [CORDIC_STEPS];
	logic signed [AZ_W-1:0] vz_s [CORDIC_STEPS];
	logic vzero_s [CORDIC_STEPS];
	logic [ANG_W-1:0] angle_s2;
	logic signed [AZ_W-1:0] zl;

	// Left half plane: start a quarter turn in, rotated by minus 90 degrees.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= (num == '0) && (den == '0);
			if (den[PROD_W-1]) begin
				x_s1 <= signed'(AX_W'(num));
				y_s1 <= -AX_W'(den);
				z_s1 <= signed'(AZ_W'(HALF_PI_Q30));
			end else begin
				x_s1 <= AX_W'(den);
				y_s1 <= signed'(AX_W'(num));
				z_s1 <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [AX_W-1:0] xi, yi, xn, yn;
		logic signed [AZ_W-1:0] zi, zn, at;
		logic zr;

		if (i == 0) begin : g_first
			assign xi = x_s1;
			assign yi = y_s1;
			assign zi = z_s1;
			assign zr = zero_s1;
		end else begin : g_next
			assign xi = vx_s[i-1];
			assign yi = vy_s[i-1];
			assign zi = vz_s[i-1];
			assign zr = vzero_s[i-1];
		end

		assign at = signed'(AZ_W'(atan_q30(i)));

		always_comb begin
			if (yi > 0) begin
				xn = xi + (yi >>> i);
				yn = yi - (xi >>> i);
				zn = zi + at;
			end else begin
				xn = xi - (yi >>> i);
				yn = yi + (xi >>> i);
				zn = zi - at;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vx_s[i] <= xn;
				vy_s[i] <= yn;
				vz_s[i] <= zn;
				vzero_s[i] <= zr;
			end
		end
	end

	assign zl = vz_s[CORDIC_STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (vzero_s[CORDIC_STEPS-1] || zl[AZ_W-1]) begin
				angle_s2 <= '0;
			end else if (zl > signed'(AZ_W'(PI_Q30))) begin
				angle_s2 <= PI_Q30;
			end else begin
				angle_s2 <= zl[ANG_W-1:0];
			end
		end
	end

	assign angle = angle_s2;

endmodule

// ===== design/great_circle_distance.sv =====
// Top level of the great circle distance pipeline.
//
// Input channel: one beat carries lat_a, lon_a, lat_b, lon_b in signed degrees
// with ANGLE_FRAC_BITS fraction bits; a beat is taken when coord_valid is high
// and coord_stall is low. Output channel: one beat per input beat, arc_distance
// in radius units with 8 fraction bits, taken when dist_valid is high and
// dist_stall is low. Results leave in input order.
// The radius register is written through sphere_radius_we/sphere_radius_wdata;
// the user must write it only while no beat is in flight, which the block
// itself does not enforce; it resets to 6371. Beats pass three sine/cosine
// CORDIC lanes, product and square stages, 32 square root stages, the atan2
// CORDIC and the radius multiply. It takes one beat per cycle unless stalled.
// Every stage moves together: while a finished result waits under dist_stall
// the whole pipeline holds and coord_stall is high, so nothing is dropped or
// repeated. Reset empties the pipeline (all valid bits clear) at once; the
// block takes beats in the first cycle after reset.
`include "great_circle_distance_defines.svh"

module great_circle_distance #(
	parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic sphere_radius_we,
	input logic [gcd_pkg::RADIUS_W-1:0] sphere_radius_wdata,
	input logic coord_valid,
	output logic coord_stall,
	input logic signed [gcd_pkg::LAT_W-1:0] lat_a,
	input logic signed [gcd_pkg::LON_W-1:0] lon_a,
	input logic signed [gcd_pkg::LAT_W-1:0] lat_b,
	input logic signed [gcd_pkg::LON_W-1:0] lon_b,
	output logic dist_valid,
	input logic dist_stall,
	output logic [gcd_pkg::DIST_W-1:0] arc_distance
);
	import gcd_pkg::*;

	localparam int LAT = 2 * CORDIC_STEPS + 47;
	localparam int SQ_STEPS = 32;

	logic adv;
	logic [LAT-1:0] vld_q;
	logic [RADIUS_W-1:0] radius_q;
	logic signed [LON_W:0] dlon;
	sincos_t tra, trb, trd;

	logic signed [PROD_W-1:0] sa, ca, sb, cb, sd, cd;
	logic signed [PROD_W-1:0] t1_s1, cbsa_s1, sbca_s1, sasb_s1, cacb_s1, cd_s1;
	logic signed [PROD_W-1:0] t1_s2, cbsa_s2, sasb_s2, p3_s2, p4_s2;
	logic signed [PROD_W-1:0] t1_s3, t2_s3, den_s3, den_s4, den_s5;
	logic signed [2*PROD_W-1:0] sq1, sq2;
	logic [63:0] sq1_s4, sq2_s4, sum_s5;
	logic [63:0] rn_s [SQ_STEPS];
	logic [63:0] rr_s [SQ_STEPS];
	logic signed [PROD_W-1:0] rd_s [SQ_STEPS];
	logic [ANG_W-1:0] ang;
	logic [RADIUS_W+ANG_W-1:0] prod_s6;
	logic [DIST_W-1:0] dist_s7;

	// Advance everything unless a result is held at the output.
	assign adv = !(dist_valid && dist_stall);
	assign coord_stall = !adv;
	assign dist_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			radius_q <= RADIUS_RESET;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[LAT-2:0], coord_valid};
			end
			if (sphere_radius_we) begin
				radius_q <= sphere_radius_wdata;
			end
		end
	end

	assign dlon = (LON_W + 1)'(lon_a) - (LON_W + 1)'(lon_b);

	gcd_sincos #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .IN_W(LAT_W)
	) u_trig_a (.clk(clk), .en(adv), .angle(lat_a), .trig(tra));

	gcd_sincos #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .IN_W(LAT_W)
	) u_trig_b (.clk(clk), .en(adv), .angle(lat_b), .trig(trb));

	gcd_sincos #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .IN_W(LON_W + 1)
	) u_trig_d (.clk(clk), .en(adv), .angle(dlon), .trig(trd));

	assign sa = PROD_W'(tra.s);
	assign ca = PROD_W'(tra.c);
	assign sb = PROD_W'(trb.s);
	assign cb = PROD_W'(trb.c);
	assign sd = PROD_W'(trd.s);
	assign cd = PROD_W'(trd.c);

	assign sq1 = t1_s3 * t1_s3;
	assign sq2 = t2_s3 * t2_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			t1_s1 <= mulq(ca, sd);
			cbsa_s1 <= mulq(cb, sa);
			sbca_s1 <= mulq(sb, ca);
			sasb_s1 <= mulq(sa, sb);
			cacb_s1 <= mulq(ca, cb);
			cd_s1 <= cd;

			p3_s2 <= mulq(sbca_s1, cd_s1);
			p4_s2 <= mulq(cacb_s1, cd_s1);
			t1_s2 <= t1_s1;
			cbsa_s2 <= cbsa_s1;
			sasb_s2 <= sasb_s1;

			t1_s3 <= t1_s2;
			t2_s3 <= cbsa_s2 - p3_s2;
			den_s3 <= sasb_s2 + p4_s2;

			sq1_s4 <= sq1[63:0];
			sq2_s4 <= sq2[63:0];
			den_s4 <= den_s3;

			sum_s5 <= sq1_s4 + sq2_s4;
			den_s5 <= den_s4;
		end
	end

	// Floor square root, one result bit per stage.
	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_root
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] ni, ri, rb;
		logic signed [PROD_W-1:0] di;

		if (i == 0) begin : g_first
			assign ni = sum_s5;
			assign ri = '0;
			assign di = den_s5;
		end else begin : g_next
			assign ni = rn_s[i-1];
			assign ri = rr_s[i-1];
			assign di = rd_s[i-1];
		end

		assign rb = ri + BIT;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (ni >= rb) begin
					rn_s[i] <= ni - rb;
					rr_s[i] <= (ri >> 1) + BIT;
				end else begin
					rn_s[i] <= ni;
					rr_s[i] <= ri >> 1;
				end
				rd_s[i] <= di;
			end
		end
	end

	gcd_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan2 (
		.clk(clk),
		.en(adv),
		.num(rr_s[SQ_STEPS-1][NUM_W-1:0]),
		.den(rd_s[SQ_STEPS-1]),
		.angle(ang)
	);

	// Radius times pi stays below the top code, so the shift alone fits.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s6 <= (RADIUS_W + ANG_W)'(radius_q) * (RADIUS_W + ANG_W)'(ang);
			dist_s7 <= prod_s6[DIST_SHIFT+DIST_W-1:DIST_SHIFT];
		end
	end

	assign arc_distance = dist_s7;

	`GCD_ASSERT_NEXT(a_hold_on_stall, dist_valid && dist_stall, $stable(vld_q), "pipeline moved under output stall")
	`GCD_ASSERT_NEXT(a_take_beat, adv, vld_q[0] == $past(coord_valid), "input beat not entered")
	`GCD_ASSERT_NOW(a_stall_needs_result, coord_stall, dist_valid, "input stalled with no waiting result")

endmodule

// ===== tb/tb_great_circle_distance.sv =====
// Self-checking testbench for the great circle distance pipeline.
module tb_great_circle_distance;
	import gcd_pkg::*;

	localparam int FRAC = 16;
	localparam int STEPS = 24;
	localparam int LATENCY = 2*STEPS + 47;
	localparam int RANDOM_ITEMS = 1900;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam longint FULL_TURN = 64'sd360 <<< FRAC;
	localparam longint HALF_TURN = 64'sd180 <<< FRAC;
	localparam longint QUARTER_TURN = 64'sd90 <<< FRAC;
	localparam longint DEG_RAD = 64'sd18740330;
	localparam longint PI_FIX = 64'sd3373259426;
	localparam longint HALF_PI_FIX = 64'sd1686629713;
	localparam longint GAIN_FIX = 64'sh26DD3B6A;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [DIST_W-1:0] NO_CHECK = '0;

	typedef struct {
		logic signed [LAT_W-1:0] la;
		logic signed [LON_W-1:0] oa;
		logic signed [LAT_W-1:0] lb;
		logic signed [LON_W-1:0] ob;
		logic [RADIUS_W-1:0] radius;
		bit fixed;
		logic [DIST_W-1:0] want;
	} coord_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sphere_radius_we = 1'b0;
	logic [RADIUS_W-1:0] sphere_radius_wdata = '0;
	logic coord_valid = 1'b0;
	logic coord_stall;
	logic signed [LAT_W-1:0] lat_a = '0;
	logic signed [LON_W-1:0] lon_a = '0;
	logic signed [LAT_W-1:0] lat_b = '0;
	logic signed [LON_W-1:0] lon_b = '0;
	logic dist_valid;
	logic dist_stall = 1'b0;
	logic [DIST_W-1:0] arc_distance;

	logic [RADIUS_W-1:0] radius_now;
	logic [DIST_W-1:0] pending_dist[$];
	int failures = 0;
	int table_errors = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit beat_taken = 0;
	coord_row_t rows[$];

	great_circle_distance u_dut (
		.clk(clk), .arst_n(arst_n),
		.sphere_radius_we(sphere_radius_we), .sphere_radius_wdata(sphere_radius_wdata),
		.coord_valid(coord_valid), .coord_stall(coord_stall),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.dist_valid(dist_valid), .dist_stall(dist_stall), .arc_distance(arc_distance)
	);

	always #4 clk = ~clk;

	function automatic longint floor_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return ~((~v) >>> s);
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		return floor_shift(a * b, 30);
	endfunction

	function automatic longint arctan_step(int i);
		return longint'(atan_q30(i));
	endfunction

	task automatic angle_sincos(input longint deg, output longint s, output longint c);
		longint r, x, y, z, xn;
		bit sneg, cneg;
		r = deg % FULL_TURN;
		cneg = 0;
		if (r < 0)
			r += FULL_TURN;
		if (r >= HALF_TURN)
			r -= FULL_TURN;
		sneg = r < 0;
		if (sneg)
			r = -r;
		if (r > QUARTER_TURN) begin
			r = HALF_TURN - r;
			cneg = 1;
		end
		z = (r * DEG_RAD) >>> FRAC;
		x = GAIN_FIX;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				xn = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= arctan_step(i);
			end else begin
				xn = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += arctan_step(i);
			end
			x = xn;
		end
		s = sneg ? -y : y;
		c = cneg ? -x : x;
	endtask

	function automatic longint floor_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint central_angle(longint num, longint den);
		longint x, y, z, xn;
		if (num == 0 && den == 0)
			return 0;
		if (den < 0) begin
			x = num; y = -den; z = HALF_PI_FIX;
		end else begin
			x = den; y = num; z = 0;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (y > 0) begin
				xn = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += arctan_step(i);
			end else begin
				xn = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= arctan_step(i);
			end
			x = xn;
		end
		if (z < 0)
			z = 0;
		if (z > PI_FIX)
			z = PI_FIX;
		return z;
	endfunction

	task automatic predict_distance(input coord_row_t r, input logic [RADIUS_W-1:0] rad,
		output logic [DIST_W-1:0] exp_dist);
		longint sa, ca, sb, cb, sd, cd, t1, t2, den, ang;
		longint unsigned sum, d;
		angle_sincos(longint'(r.la), sa, ca);
		angle_sincos(longint'(r.lb), sb, cb);
		angle_sincos(longint'(r.oa) - longint'(r.ob), sd, cd);
		t1 = q30_mul(ca, sd);
		t2 = q30_mul(cb, sa) - q30_mul(q30_mul(sb, ca), cd);
		sum = longint'(t1 * t1) + longint'(t2 * t2);
		den = q30_mul(sa, sb) + q30_mul(q30_mul(ca, cb), cd);
		ang = central_angle(floor_sqrt(sum), den);
		d = (longint'(rad) * ang) >> DIST_SHIFT;
		exp_dist = (d > DIST_MAX) ? DIST_MAX : d[DIST_W-1:0];
	endtask

	function automatic coord_row_t make_row(int la, int oa, int lb, int ob,
		logic [RADIUS_W-1:0] rad, bit fixed, logic [DIST_W-1:0] want);
		coord_row_t r;
		r.la = LAT_W'(la); r.oa = LON_W'(oa); r.lb = LAT_W'(lb); r.ob = LON_W'(ob);
		r.radius = rad; r.fixed = fixed; r.want = want;
		return r;
	endfunction

	// Random latitude/longitude, mostly in range, sometimes any bit pattern.
	function automatic coord_row_t random_row(logic [RADIUS_W-1:0] rad);
		coord_row_t r;
		if ($urandom_range(0, 9) == 0) begin
			r.la = LAT_W'($urandom); r.oa = LON_W'($urandom);
			r.lb = LAT_W'($urandom); r.ob = LON_W'($urandom);
		end else begin
			r.la = LAT_W'($signed($urandom_range(0, 11796480)) - 5898240);
			r.oa = LON_W'($signed($urandom_range(0, 23592960)) - 11796480);
			r.lb = LAT_W'($signed($urandom_range(0, 11796480)) - 5898240);
			r.ob = LON_W'($signed($urandom_range(0, 23592960)) - 11796480);
			if ($urandom_range(0, 7) == 0) begin
				r.lb = r.la;
				r.ob = LON_W'(r.oa + $signed($urandom_range(0, 64)) - 32);
			end else if ($urandom_range(0, 7) == 0) begin
				// near the antipode
				r.lb = -r.la;
				r.ob = LON_W'(r.oa + 11796480 + $signed($urandom_range(0, 64)) - 32);
			end
		end
		r.radius = rad; r.fixed = 0; r.want = NO_CHECK;
		return r;
	endfunction

	task automatic write_radius(input logic [RADIUS_W-1:0] v);
		@(negedge clk);
		sphere_radius_we <= 1'b1;
		sphere_radius_wdata <= v;
		@(negedge clk);
		sphere_radius_we <= 1'b0;
		radius_now = v;
	endtask

	task automatic drain_and_settle();
		coord_valid <= 1'b0;
		while (pending_dist.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Hold valid after a beat until the next gap is known, so back-to-back beats need no drop.
	task automatic send_row(input coord_row_t r);
		logic [DIST_W-1:0] d;
		int gap;
		if (r.radius != radius_now) begin
			drain_and_settle();
			write_radius(r.radius);
		end
		gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
		if (gap > 0) begin
			coord_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		predict_distance(r, radius_now, d);
		if (r.fixed && d != r.want) begin
			$display("%0t: table row disagrees: expected %0d predicted %0d", $time, r.want, d);
			table_errors++;
		end
		coord_valid <= 1'b1;
		lat_a <= r.la; lon_a <= r.oa; lat_b <= r.lb; lon_b <= r.ob;
		@(posedge clk);
		while (coord_stall)
			@(posedge clk);
		pending_dist.push_back(r.fixed ? r.want : d);
		@(negedge clk);
	endtask

	// Result side: after each beat, stall for a drawn number of cycles.
	always @(negedge clk) begin
		if (beat_taken)
			stall_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
		if (stall_left > 0) begin
			dist_stall <= 1'b1;
			stall_left--;
		end else begin
			dist_stall <= 1'b0;
		end
	end

	// Compare each beat with the oldest expectation.
	always @(posedge clk) begin
		beat_taken <= arst_n && dist_valid && !dist_stall;
		if (arst_n) begin
			if ((coord_valid && !coord_stall) || (dist_valid && !dist_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (dist_valid && !dist_stall) begin
				if (pending_dist.size() == 0) begin
					$display("%0t: unexpected beat: expected none actual %0d", $time, arc_distance);
					failures++;
				end else begin
					if (arc_distance !== pending_dist[0]) begin
						$display("%0t: arc_distance mismatch: expected %0d actual %0d",
							$time, pending_dist[0], arc_distance);
						failures++;
					end
					void'(pending_dist.pop_front());
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_great_circle_distance failed");
				$finish;
			end
		end
	end

	initial begin
		radius_now = RADIUS_RESET;
		// Coincident points give zero; radius zero gives zero; extremes of every field.
		rows.push_back(make_row(0, 0, 0, 0, RADIUS_RESET, 1, NO_CHECK));
		rows.push_back(make_row(5898240, 11796480, 5898240, 11796480, RADIUS_RESET, 1, NO_CHECK));
		rows.push_back(make_row(0, 0, 0, 11796480, RADIUS_RESET, 0, NO_CHECK));
		rows.push_back(make_row(5898240, 0, -5898240, 0, RADIUS_RESET, 0, NO_CHECK));
		rows.push_back(make_row(-5898240, -11796480, 5898240, 11796480, RADIUS_RESET, 0, NO_CHECK));
		rows.push_back(make_row(0, -11796480, 0, 11796480, RADIUS_RESET, 0, NO_CHECK));
		rows.push_back(make_row(0, 0, 0, 1, RADIUS_RESET, 0, NO_CHECK));
		rows.push_back(make_row(8388607, 16777215, -8388608, -16777216, RADIUS_RESET, 0,
			NO_CHECK));
		rows.push_back(make_row(-8388608, -16777216, 8388607, 16777215, RADIUS_RESET, 0,
			NO_CHECK));
		rows.push_back(make_row(-1, -1, 1, 1, RADIUS_RESET, 0, NO_CHECK));
		rows.push_back(make_row(5898240, 0, -5898240, 0, 0, 1, NO_CHECK));
		rows.push_back(make_row(1234567, 222, -333, 4444444, 0, 1, NO_CHECK));
		rows.push_back(make_row(0, 0, 0, 11796480, 24'hFFFFFF, 0, NO_CHECK));
		rows.push_back(make_row(5898240, 0, -5898240, 0, 24'hFFFFFF, 0, NO_CHECK));
		rows.push_back(make_row(0, 0, 0, 65536, 24'hFFFFFF, 0, NO_CHECK));
		rows.push_back(make_row(0, 0, 0, 65536, 1, 0, NO_CHECK));
		rows.push_back(make_row(3000000, -7000000, -2000000, 9000000, 1, 0, NO_CHECK));
		rows.push_back(make_row(0, 0, 0, 0, 1, 1, NO_CHECK));
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (rows[i])
			send_row(rows[i]);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			logic [RADIUS_W-1:0] rad;
			rad = radius_now;
			if (n % 400 == 399)
				rad = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF :
					RADIUS_W'($urandom_range(0, 100000));
			if (n == 1000)
				drain_and_settle();
			send_row(random_row(rad));
		end
		drain_and_settle();
		if (failures == 0 && table_errors == 0)
			$display("tb_great_circle_distance passed");
		else
			$display("tb_great_circle_distance failed");
		$finish;
	end
endmodule
